FILE: rtl/spwa_pkg.sv
package spwa_pkg;

    localparam int NUM_WALKERS_DEF = 16;
    localparam int NUM_NPUS_DEF    = 4;
    localparam int MAX_LEVELS_DEF  = 4;

    localparam int TICK_W  = 48;
    localparam int PAGE_W  = 52;
    localparam int REQ_W   = 2;
    localparam int WID_W   = 4;
    localparam int LAT_W   = 16;
    localparam int ADDR_W  = 6;
    localparam int CIDX_W  = 16;

    // register indexes
    localparam logic [2:0] REG_WALK_LATENCY  = 3'd0;
    localparam logic [2:0] REG_LEVEL_COUNT   = 3'd1;
    localparam logic [2:0] REG_OFFSET_BITS   = 3'd2;
    localparam logic [2:0] REG_PATH_CACHE    = 3'd3;
    localparam logic [2:0] REG_PARTITION     = 3'd4;
    localparam logic [2:0] REG_RETURN_MODE   = 3'd5;
    localparam logic [2:0] REG_BOUNDS        = 3'd6;
    localparam logic [2:0] REG_INIT_SHARES   = 3'd7;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_LEVEL  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_UPDATE = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

endpackage

FILE: rtl/spwa_lat_div.sv
// walk latency divided by the level count, one quotient bit per cycle
module spwa_lat_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [spwa_pkg::LAT_W-1:0] dividend,
    input  logic [2:0]                divisor,
    output logic                      done,
    output logic [spwa_pkg::LAT_W-1:0] quotient
);
    import spwa_pkg::*;

    logic [LAT_W-1:0] quo_reg;
    logic [LAT_W-1:0] quo_next;
    logic [2:0]       rem_reg;
    logic [2:0]       rem_next;
    logic [4:0]       cnt_reg;
    logic [4:0]       cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic [3:0]       trial;

    // restoring division step
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[LAT_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = 3'd0;
            cnt_next  = 5'(LAT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = 3'(trial - {1'b0, divisor});
                quo_next = {quo_reg[LAT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[2:0];
                quo_next = {quo_reg[LAT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = busy_reg && (cnt_reg == 5'd1);
    assign quotient = quo_next;

endmodule

FILE: rtl/shared_page_walker_allocator.sv
// shared page walker allocator
// s_axis carries one walk request: tdata holds page_number, requester and
// now_tick; m_axis returns one result: granted, walker_used and done_tick.
// configuration registers sit on the apb port at byte address 8*i, since one
// register is 64 bits wide; writes to partition registers reload
// ownership, shares and limits and empty the requester history.
// a request passes acceptance, a scan in which a single compare unit checks
// the walkers' free ticks one by one, then with the path cache on a compare
// of the cache level by level, the bit-serial latency divider and a multiply
// step, then an update step and an output step that holds while the receiver
// stalls. an out-of-range requester skips to output at acceptance, and a
// request with no eligible walker goes to output after the scan.
// only one request is in flight; s_axis_tready is low from acceptance until
// the result is taken, so a stalled receiver holds the block.
// reset clears free ticks and the path cache and loads ownership from the
// reset values of the registers (all walkers unowned).
module shared_page_walker_allocator #(
    parameter int NUM_WALKERS = spwa_pkg::NUM_WALKERS_DEF,
    parameter int NUM_NPUS    = spwa_pkg::NUM_NPUS_DEF,
    parameter int MAX_LEVELS  = spwa_pkg::MAX_LEVELS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // page_number[51:0], requester[53:52], now_tick[101:54], zero fill
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // granted[0], walker_used[4:1], done_tick[52:5], zero fill
    output logic [55:0]  m_axis_tdata
);
    import spwa_pkg::*;

    localparam int WI_W   = (NUM_WALKERS > 1) ? $clog2(NUM_WALKERS) : 1;
    localparam int CNT_W  = $clog2(NUM_WALKERS + 1);
    localparam int OWN_W  = $clog2(NUM_NPUS + 1);
    localparam int NPU_W  = (NUM_NPUS > 1) ? $clog2(NUM_NPUS) : 1;
    localparam int LV_W   = $clog2(MAX_LEVELS + 1);
    localparam int LI_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int HIST_W = $clog2(NUM_WALKERS + 1);
    localparam int EQ_SHARE = NUM_WALKERS / NUM_NPUS;

    // configuration registers
    logic [LAT_W-1:0] walk_latency_reg;
    logic [2:0]       level_count_reg;
    logic [4:0]       offset_bits_reg;
    logic             path_cache_en_reg;
    logic             partition_en_reg;
    logic             return_mode_reg;
    logic [63:0]      bounds_reg;
    logic [31:0]      init_shares_reg;

    // allocator state
    logic [TICK_W-1:0] free_tick_reg [NUM_WALKERS];
    logic [OWN_W-1:0]  owner_reg     [NUM_WALKERS];
    logic [CNT_W-1:0]  share_reg     [NUM_NPUS];
    logic [7:0]        upper_reg     [NUM_NPUS];
    logic [7:0]        lower_reg     [NUM_NPUS];
    logic [CIDX_W-1:0] pcache_reg    [MAX_LEVELS];
    logic [NPU_W-1:0]  hist_reg      [NUM_WALKERS];
    logic [HIST_W-1:0] hist_fill_reg;
    logic              reload_reg;

    // request registers
    logic [2:0]        state_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [TICK_W-1:0] now_reg;
    logic [WI_W-1:0]   scan_reg;
    logic              found_reg;
    logic [WI_W-1:0]   pick_reg;
    logic [TICK_W-1:0] best_reg;
    logic [LI_W-1:0]   lvl_reg;
    logic [LV_W-1:0]   stop_reg;
    logic              stop_set_reg;
    logic [LAT_W-1:0]  lat_reg;
    logic [TICK_W-1:0] done_reg;
    logic              granted_reg;
    logic [WI_W-1:0]   out_walker_reg;

    // write decode
    logic       cfg_wr;
    logic [2:0] cfg_idx;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[5:3];

    always_comb
    begin
        unique case (paddr[5:3])
            REG_WALK_LATENCY: prdata = 64'(walk_latency_reg);
            REG_LEVEL_COUNT:  prdata = 64'(level_count_reg);
            REG_OFFSET_BITS:  prdata = 64'(offset_bits_reg);
            REG_PATH_CACHE:   prdata = 64'(path_cache_en_reg);
            REG_PARTITION:    prdata = 64'(partition_en_reg);
            REG_RETURN_MODE:  prdata = 64'(return_mode_reg);
            REG_BOUNDS:       prdata = bounds_reg;
            default:          prdata = 64'(init_shares_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_latency_reg  <= 16'd100;
            level_count_reg   <= 3'd4;
            offset_bits_reg   <= 5'd12;
            path_cache_en_reg <= 1'b0;
            partition_en_reg  <= 1'b0;
            return_mode_reg   <= 1'b0;
            bounds_reg        <= '0;
            init_shares_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_WALK_LATENCY: walk_latency_reg  <= pwdata[15:0];
                REG_LEVEL_COUNT:  level_count_reg   <= pwdata[2:0];
                REG_OFFSET_BITS:  offset_bits_reg   <= pwdata[4:0];
                REG_PATH_CACHE:   path_cache_en_reg <= pwdata[0];
                REG_PARTITION:    partition_en_reg  <= pwdata[0];
                REG_RETURN_MODE:  return_mode_reg   <= pwdata[0];
                REG_BOUNDS:       bounds_reg        <= pwdata;
                default:          init_shares_reg   <= pwdata[31:0];
            endcase
        end
    end

    // effective level count and index width
    logic [LV_W-1:0] nlev;
    logic [6:0]      idx_width;
    logic [6:0]      idx_span;
    logic [15:0]     span_x171;
    logic [15:0]     span_x205;
    always_comb
    begin
        if (level_count_reg == 3'd0)
        begin
            nlev = LV_W'(1);
        end
        else if (int'(level_count_reg) > MAX_LEVELS)
        begin
            nlev = LV_W'(MAX_LEVELS);
        end
        else
        begin
            nlev = LV_W'(level_count_reg);
        end
        // (64 - bits) / nlev by shifts and reciprocal multiplies, span <= 64
        idx_span  = 7'd64 - 7'(offset_bits_reg);
        span_x171 = 16'(idx_span) * 16'd171;
        span_x205 = 16'(idx_span) * 16'd205;
        case (nlev)
            LV_W'(1): idx_width = idx_span;
            LV_W'(2): idx_width = {1'b0, idx_span[6:1]};
            LV_W'(3): idx_width = 7'(span_x171 >> 9);
            LV_W'(5): idx_width = 7'(span_x205 >> 10);
            LV_W'(6): idx_width = 7'(span_x171 >> 10);
            default:  idx_width = {2'b00, idx_span[6:2]};
        endcase
    end

    // eligibility of the walker under scan
    logic              elig;
    logic [OWN_W-1:0]  scan_own;
    logic [CNT_W-1:0]  req_share;
    logic [CNT_W-1:0]  own_share;
    logic [7:0]        own_lower;
    always_comb
    begin
        scan_own  = owner_reg[scan_reg];
        req_share = share_reg[req_reg[NPU_W-1:0]];
        own_share = share_reg[scan_own[NPU_W-1:0]];
        own_lower = lower_reg[scan_own[NPU_W-1:0]];
        if (!partition_en_reg)
        begin
            elig = 1'b1;
        end
        else
        begin
            elig = (scan_own == OWN_W'(req_reg)) ||
                   ((8'(req_share) < upper_reg[req_reg[NPU_W-1:0]]) &&
                    ((int'(scan_own) >= NUM_NPUS) || (8'(own_share) > own_lower)));
        end
    end

    // level index of the level under compare (cache slot lvl holds level nlev-lvl)
    logic [CIDX_W-1:0] cur_idx;
    logic [8:0]        lvl_shift;
    logic [63:0]       shifted;
    logic [63:0]       idx_mask;
    always_comb
    begin
        lvl_shift = 9'(idx_width * 7'(nlev - LV_W'(lvl_reg) - LV_W'(1)));
        shifted   = (lvl_shift >= 9'd64) ? 64'd0 : (64'(page_reg) >> lvl_shift[5:0]);
        idx_mask  = (idx_width >= 7'd64) ? ~64'd0 : ((64'd1 << idx_width[5:0]) - 64'd1);
        cur_idx   = CIDX_W'(shifted & idx_mask);
    end

    // latency divider
    logic             div_start;
    logic             div_done;
    logic [LAT_W-1:0] div_quo;
    spwa_lat_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (walk_latency_reg),
        .divisor  (3'(nlev)),
        .done     (div_done),
        .quotient (div_quo)
    );
    assign div_start = (state_reg == ST_LEVEL) &&
                       (int'(lvl_reg) + 1 >= int'(nlev));

    // history mixed check over the filled entries
    logic mixed_now;
    always_comb
    begin
        mixed_now = 1'b0;
        for (int k = 0; k < NUM_WALKERS; k++)
        begin
            if ((HIST_W'(k) < hist_fill_reg) && (hist_reg[k] != req_reg[NPU_W-1:0]))
            begin
                mixed_now = 1'b1;
            end
        end
    end

    logic              s_acc;
    logic              m_acc;
    logic [TICK_W-1:0] start_tick;
    assign s_acc  = s_axis_tvalid && s_axis_tready;
    assign m_acc  = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && !reload_reg;
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {3'd0, done_reg, out_walker_reg[WID_W-1:0] & {WID_W{1'b1}},
                            granted_reg};
    assign start_tick = (best_reg > now_reg) ? best_reg : now_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            found_reg    <= 1'b0;
            granted_reg  <= 1'b0;
            stop_set_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_acc)
                    begin
                        found_reg <= 1'b0;
                        if (int'(s_axis_tdata[53:52]) >= NUM_NPUS)
                        begin
                            granted_reg <= 1'b0;
                            state_reg   <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (elig && (!found_reg || free_tick_reg[scan_reg] < best_reg))
                    begin
                        found_reg <= 1'b1;
                    end
                    if (int'(scan_reg) == NUM_WALKERS - 1)
                    begin
                        if (!(found_reg || elig))
                        begin
                            granted_reg <= 1'b0;
                            state_reg   <= ST_OUT;
                        end
                        else if (path_cache_en_reg)
                        begin
                            stop_set_reg <= 1'b0;
                            state_reg    <= ST_LEVEL;
                        end
                        else
                        begin
                            state_reg <= ST_UPDATE;
                        end
                    end
                end
                ST_LEVEL:
                begin
                    if (pcache_reg[lvl_reg] != cur_idx)
                    begin
                        stop_set_reg <= 1'b1;
                    end
                    if (div_start)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    granted_reg <= 1'b1;
                    state_reg   <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (m_acc)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                page_reg <= s_axis_tdata[51:0];
                req_reg  <= s_axis_tdata[53:52];
                now_reg  <= s_axis_tdata[101:54];
                scan_reg <= '0;
                lvl_reg  <= '0;
                stop_reg <= nlev;
                done_reg       <= '0;
                out_walker_reg <= '0;
            end
            ST_SCAN:
            begin
                if (elig && (!found_reg || free_tick_reg[scan_reg] < best_reg))
                begin
                    pick_reg <= scan_reg;
                    best_reg <= free_tick_reg[scan_reg];
                end
                if (int'(scan_reg) != NUM_WALKERS - 1)
                begin
                    scan_reg <= scan_reg + WI_W'(1);
                end
                lat_reg <= walk_latency_reg;
            end
            ST_LEVEL:
            begin
                if (pcache_reg[lvl_reg] != cur_idx && !stop_set_reg)
                begin
                    stop_reg <= LV_W'(lvl_reg);
                end
                if (!div_start)
                begin
                    lvl_reg <= lvl_reg + LI_W'(1);
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    lat_reg <= div_quo;
                end
            end
            ST_MUL:
            begin
                lat_reg <= LAT_W'(lat_reg * LAT_W'(nlev - stop_reg));
            end
            ST_UPDATE:
            begin
                done_reg       <= TICK_W'(start_tick + TICK_W'(lat_reg));
                out_walker_reg <= pick_reg;
            end
            default:
            begin
            end
        endcase
    end

    // path cache: write each level as it is compared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                pcache_reg[i] <= '0;
            end
        end
        else if (state_reg == ST_LEVEL)
        begin
            pcache_reg[lvl_reg] <= cur_idx;
        end
    end

    // free ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NUM_WALKERS; w++)
            begin
                free_tick_reg[w] <= '0;
            end
        end
        else if (state_reg == ST_UPDATE)
        begin
            free_tick_reg[pick_reg] <= TICK_W'(start_tick + TICK_W'(lat_reg));
        end
    end

    // history ring kept as a shift line, oldest at entry 0
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE && partition_en_reg && return_mode_reg)
        begin
            if (int'(hist_fill_reg) == NUM_WALKERS)
            begin
                for (int k = 0; k < NUM_WALKERS - 1; k++)
                begin
                    hist_reg[k] <= hist_reg[k+1];
                end
                hist_reg[NUM_WALKERS-1] <= req_reg[NPU_W-1:0];
            end
            else
            begin
                hist_reg[hist_fill_reg[WI_W-1:0]] <= req_reg[NPU_W-1:0];
            end
        end
    end

    // ownership, shares, limits; reload runs the cycle after a partition write
    logic [CNT_W-1:0] ld_share [NUM_NPUS];
    logic [OWN_W-1:0] ld_owner [NUM_WALKERS];
    always_comb
    begin
        int nxt;
        int want;
        int got;
        nxt = 0;
        for (int w = 0; w < NUM_WALKERS; w++)
        begin
            ld_owner[w] = OWN_W'(NUM_NPUS);
        end
        for (int n = 0; n < NUM_NPUS; n++)
        begin
            want = (n < 4) ? int'(init_shares_reg[8*(n%4) +: 8]) : 0;
            got  = 0;
            for (int w = 0; w < NUM_WALKERS; w++)
            begin
                if (w >= nxt && w < nxt + want)
                begin
                    ld_owner[w] = OWN_W'(n);
                    got = got + 1;
                end
            end
            nxt = nxt + got;
            ld_share[n] = CNT_W'(got);
        end
    end

    logic own_changed;
    logic [OWN_W-1:0] pick_own;
    assign pick_own    = owner_reg[pick_reg];
    assign own_changed = (pick_own != OWN_W'(req_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg    <= 1'b1;
            hist_fill_reg <= '0;
            for (int w = 0; w < NUM_WALKERS; w++)
            begin
                owner_reg[w] <= OWN_W'(NUM_NPUS);
            end
            for (int n = 0; n < NUM_NPUS; n++)
            begin
                share_reg[n] <= '0;
                upper_reg[n] <= '0;
                lower_reg[n] <= '0;
            end
        end
        else if (cfg_wr && (cfg_idx == REG_PARTITION || cfg_idx == REG_RETURN_MODE ||
                            cfg_idx == REG_BOUNDS || cfg_idx == REG_INIT_SHARES))
        begin
            reload_reg <= 1'b1;
        end
        else if (reload_reg)
        begin
            reload_reg    <= 1'b0;
            hist_fill_reg <= '0;
            for (int w = 0; w < NUM_WALKERS; w++)
            begin
                owner_reg[w] <= ld_owner[w];
            end
            for (int n = 0; n < NUM_NPUS; n++)
            begin
                share_reg[n] <= ld_share[n];
                if (return_mode_reg)
                begin
                    upper_reg[n] <= 8'(NUM_WALKERS);
                    lower_reg[n] <= 8'd0;
                end
                else if (n < 4)
                begin
                    upper_reg[n] <= bounds_reg[16*(n%4) +: 8];
                    lower_reg[n] <= bounds_reg[16*(n%4)+8 +: 8];
                end
                else
                begin
                    upper_reg[n] <= 8'd0;
                    lower_reg[n] <= 8'd0;
                end
            end
        end
        else if (state_reg == ST_UPDATE && partition_en_reg)
        begin
            if (return_mode_reg && !mixed_now)
            begin
                // requester takes every walker
                for (int w = 0; w < NUM_WALKERS; w++)
                begin
                    owner_reg[w] <= OWN_W'(req_reg);
                end
                for (int n = 0; n < NUM_NPUS; n++)
                begin
                    share_reg[n] <= (n == int'(req_reg)) ? CNT_W'(NUM_WALKERS) : '0;
                end
            end
            else
            begin
                owner_reg[pick_reg] <= OWN_W'(req_reg);
                if (own_changed)
                begin
                    share_reg[req_reg[NPU_W-1:0]] <=
                        share_reg[req_reg[NPU_W-1:0]] + CNT_W'(1);
                    if ((int'(pick_own) < NUM_NPUS) &&
                        (share_reg[pick_own[NPU_W-1:0]] != '0))
                    begin
                        share_reg[pick_own[NPU_W-1:0]] <=
                            share_reg[pick_own[NPU_W-1:0]] - CNT_W'(1);
                    end
                end
            end
            if (return_mode_reg)
            begin
                if (mixed_now)
                begin
                    for (int n = 0; n < NUM_NPUS; n++)
                    begin
                        upper_reg[n] <= 8'(EQ_SHARE);
                        lower_reg[n] <= 8'(EQ_SHARE);
                    end
                end
                if (int'(hist_fill_reg) != NUM_WALKERS)
                begin
                    hist_fill_reg <= hist_fill_reg + HIST_W'(1);
                end
            end
        end
    end

endmodule

FILE: tb/testbench.sv
// walk scoreboard: predicts each walk grant and compares it with the block's result
class walk_scoreboard;
    typedef struct {
        bit        granted;
        bit [3:0]  walker;
        bit [47:0] done_tick;
    } grant_t;

    grant_t    grants_due[$];
    int        errors;
    int        results_seen;
    int        grants_seen;

    // register copies
    bit [15:0] walk_lat;
    bit [2:0]  lev_reg;
    bit [4:0]  offset_bits;
    bit        cache_on;
    bit        part_on;
    bit        return_on;
    bit [63:0] bounds;
    bit [31:0] shares;

    // block state
    bit [47:0] free_tick [16];
    bit [2:0]  owner [16];
    bit [7:0]  share_cnt [4];
    bit [7:0]  upper [4];
    bit [7:0]  lower [4];
    bit [15:0] level_cache [4];
    bit [1:0]  history [16];
    int        hist_head;
    int        hist_fill;

    function void reload();
        int nxt;
        int want;
        int got;
        nxt = 0;
        for (int w = 0; w < 16; w++)
            owner[w] = 3'd4;
        for (int n = 0; n < 4; n++)
        begin
            want = int'(shares[8*n +: 8]);
            got = 0;
            while (got < want && nxt < 16)
            begin
                owner[nxt] = 3'(n);
                nxt++;
                got++;
            end
            share_cnt[n] = 8'(got);
            if (return_on)
            begin
                upper[n] = 8'd16;
                lower[n] = 8'd0;
            end
            else
            begin
                upper[n] = bounds[16*n +: 8];
                lower[n] = bounds[16*n+8 +: 8];
            end
        end
        for (int k = 0; k < 16; k++)
            history[k] = 2'd0;
        hist_head = 0;
        hist_fill = 0;
    endfunction

    function void reset_state();
        walk_lat = 16'd100;
        lev_reg = 3'd4;
        offset_bits = 5'd12;
        cache_on = 0;
        part_on = 0;
        return_on = 0;
        bounds = '0;
        shares = '0;
        for (int w = 0; w < 16; w++)
            free_tick[w] = '0;
        for (int i = 0; i < 4; i++)
            level_cache[i] = '0;
        reload();
    endfunction

    function void write_reg(logic [2:0] idx, bit [63:0] v);
        case (idx)
            spwa_pkg::REG_WALK_LATENCY: walk_lat = v[15:0];
            spwa_pkg::REG_LEVEL_COUNT:  lev_reg = v[2:0];
            spwa_pkg::REG_OFFSET_BITS:  offset_bits = v[4:0];
            spwa_pkg::REG_PATH_CACHE:   cache_on = v[0];
            spwa_pkg::REG_PARTITION:
            begin
                part_on = v[0];
                reload();
            end
            spwa_pkg::REG_RETURN_MODE:
            begin
                return_on = v[0];
                reload();
            end
            spwa_pkg::REG_BOUNDS:
            begin
                bounds = v;
                reload();
            end
            default:
            begin
                shares = v[31:0];
                reload();
            end
        endcase
    endfunction

    // predict the grant for one accepted walk request
    function void note_request(bit [103:0] d);
        bit [63:0] page;
        int        req;
        bit [47:0] now;
        bit [63:0] best;
        int        pick;
        bit        ok;
        int        own;
        bit [47:0] t;
        bit [63:0] lat;
        int        nlev;
        int        stop;
        int        width;
        int        shift;
        bit [63:0] mask;
        bit [63:0] v;
        bit [15:0] idx;
        bit        mixed;
        grant_t    g;
        page = {12'd0, d[51:0]};
        req = int'(d[53:52]);
        now = d[101:54];
        best = '1;
        pick = -1;
        g = '{0, 4'd0, 48'd0};
        for (int w = 0; w < 16; w++)
        begin
            if ({16'd0, free_tick[w]} < best)
            begin
                if (!part_on)
                    ok = 1;
                else
                begin
                    own = owner[w];
                    ok = (own == req) || (share_cnt[req] < upper[req] &&
                         (own >= 4 || share_cnt[own] > lower[own]));
                end
                if (ok)
                begin
                    pick = w;
                    best = {16'd0, free_tick[w]};
                end
            end
        end
        if (pick >= 0)
        begin
            t = free_tick[pick] > now ? free_tick[pick] : now;
            if (cache_on)
            begin
                nlev = lev_reg == 0 ? 1 : (lev_reg > 4 ? 4 : lev_reg);
                stop = nlev;
                width = (64 - offset_bits) / nlev;
                for (int i = 0; i < nlev; i++)
                begin
                    shift = width * (nlev - i - 1);
                    mask = width >= 64 ? '1 : ((64'd1 << width) - 1);
                    v = shift >= 64 ? 64'd0 : (page >> shift);
                    idx = 16'(v & mask);
                    if (level_cache[i] != idx && stop == nlev)
                        stop = i;
                    level_cache[i] = idx;
                end
                lat = (walk_lat / nlev) * (nlev - stop);
            end
            else
                lat = walk_lat;
            t = t + lat[47:0];
            free_tick[pick] = t;
            if (part_on)
            begin
                own = owner[pick];
                if (own != req)
                begin
                    share_cnt[req]++;
                    if (own < 4 && share_cnt[own] > 0)
                        share_cnt[own]--;
                end
                owner[pick] = 3'(req);
                if (return_on)
                begin
                    mixed = 0;
                    for (int k = 0; k < hist_fill; k++)
                        if (history[(hist_head + k) % 16] != req)
                            mixed = 1;
                    if (mixed)
                    begin
                        for (int n = 0; n < 4; n++)
                        begin
                            upper[n] = 8'd4;
                            lower[n] = 8'd4;
                        end
                    end
                    else
                    begin
                        for (int w = 0; w < 16; w++)
                            owner[w] = 3'(req);
                        for (int n = 0; n < 4; n++)
                            share_cnt[n] = 0;
                        share_cnt[req] = 8'd16;
                    end
                    if (hist_fill == 16)
                    begin
                        hist_head = (hist_head + 1) % 16;
                        hist_fill--;
                    end
                    history[(hist_head + hist_fill) % 16] = 2'(req);
                    hist_fill++;
                end
            end
            g = '{1, pick[3:0], t};
        end
        grants_due.push_back(g);
    endfunction

    // compare one result with the oldest predicted grant
    function void check_result(bit [55:0] d);
        grant_t g;
        results_seen++;
        if (grants_due.size() == 0)
        begin
            $error("result with no request pending: %h", d);
            errors++;
            return;
        end
        g = grants_due.pop_front();
        if (g.granted)
            grants_seen++;
        if (d[0] != g.granted)
        begin
            $error("granted: expected %0d actual %0d", g.granted, d[0]);
            errors++;
        end
        if (d[4:1] != g.walker)
        begin
            $error("walker_used: expected %0d actual %0d", g.walker, d[4:1]);
            errors++;
        end
        if (d[52:5] != g.done_tick)
        begin
            $error("done_tick: expected %h actual %h", g.done_tick, d[52:5]);
            errors++;
        end
    endfunction
endclass

module testbench;
    import spwa_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic         clk = 0;
    logic         rst_n = 0;
    logic         psel = 0;
    logic         penable = 0;
    logic         pwrite = 0;
    logic [5:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    // page_number[51:0], requester[53:52], now_tick[101:54], zero fill
    logic [103:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    // granted[0], walker_used[4:1], done_tick[52:5], zero fill
    logic [55:0]  m_axis_tdata;

    walk_scoreboard sb = new();
    int           send_idle = 0;
    int           recv_idle = 0;
    int           quiet_cycles = 0;
    bit [51:0]    last_page = '0;
    bit [1:0]     last_req = '0;
    bit [47:0]    base_tick = '0;

    shared_page_walker_allocator uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #10 clk = ~clk;

    // receiver stalls
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle);

    // monitor both streams and watch for a hang
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            sb.note_request(s_axis_tdata);
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] v);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= {idx, 3'b000};
        pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        sb.write_reg(idx, v);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic send_request(bit [51:0] page, bit [1:0] req, bit [47:0] now);
        if ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {2'b00, now, req, page};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // hold the sender until every predicted grant has arrived
    task automatic drain();
        s_axis_tvalid <= 0;
        // let the monitor note the last accepted request first
        @(posedge clk);
        while (sb.grants_due.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // mostly nearby pages and ticks so walkers contend and the path cache hits
    task automatic send_random(bit sticky_req);
        bit [51:0] page;
        bit [1:0]  req;
        bit [47:0] now;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 30)
            page = last_page;
        else if (pick < 75)
            page = last_page ^ (52'd1 << $urandom_range(51));
        else
            page = 52'({$urandom, $urandom});
        if (sticky_req && $urandom_range(99) < 80)
            req = last_req;
        else
            req = 2'($urandom);
        base_tick = base_tick + 48'($urandom_range(60));
        pick = $urandom_range(99);
        if (pick < 4)
            now = 48'({$urandom, $urandom});
        else if (pick < 6)
            now = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(300));
        else
            now = base_tick + 48'($urandom_range(30));
        last_page = page;
        last_req = req;
        send_request(page, req, now);
    endtask

    // reprogram every register for one phase
    task automatic setup_phase(int p);
        logic [63:0] bnd;
        logic [31:0] shr;
        logic [15:0] lat;
        logic [2:0]  lev;
        logic [4:0]  off;
        case (p % 4)
            0: lat = 16'd0;
            1: lat = 16'hFFFF;
            default: lat = 16'($urandom);
        endcase
        lev = (p % 5 == 4) ? 3'd7 : ((p % 7 == 6) ? 3'd0 : 3'($urandom_range(1, 4)));
        off = (p % 3 == 0) ? 5'd30 : ((p % 3 == 1) ? 5'd12 : 5'($urandom_range(12, 30)));
        if (p % 4 == 0)
            shr = {8'd4, 8'd4, 8'd4, 8'd4};
        else if (p % 4 == 1)
            shr = {8'hFF, 8'd10, 8'd3, 8'd9};
        else
            shr = {8'($urandom_range(6)), 8'($urandom_range(6)),
                   8'($urandom_range(6)), 8'($urandom_range(6))};
        bnd = '0;
        for (int n = 0; n < 4; n++)
        begin
            bnd[16*n +: 8] = (p % 6 == 5) ? 8'hFF : 8'($urandom_range(16));
            bnd[16*n+8 +: 8] = 8'($urandom_range(6));
        end
        if (p % 9 == 8)
            bnd = {$urandom, $urandom};
        write_reg(REG_WALK_LATENCY, lat);
        write_reg(REG_LEVEL_COUNT, lev);
        write_reg(REG_OFFSET_BITS, off);
        write_reg(REG_PATH_CACHE, (p % 3) != 2);
        write_reg(REG_PARTITION, (p % 4) != 3);
        write_reg(REG_RETURN_MODE, p[0]);
        write_reg(REG_BOUNDS, bnd);
        write_reg(REG_INIT_SHARES, shr);
    endtask

    initial
    begin
        sb.reset_state();
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: field extremes with reset settings, then special cases
        send_idle = 14;
        recv_idle = 70;
        send_request('0, 2'd0, '0);
        send_request('1, 2'd3, '1);
        send_request('1, 2'd1, 48'hFFFF_FFFF_FFF0);
        send_request(52'h5_5555_5555_5555, 2'd2, 48'h5555_5555_5555);
        send_request(52'hA_AAAA_AAAA_AAAA, 2'd1, 48'hAAAA_AAAA_AAAA);
        drain();
        // path cache with a single very wide level index
        write_reg(REG_PATH_CACHE, 1);
        write_reg(REG_LEVEL_COUNT, 3'd1);
        write_reg(REG_OFFSET_BITS, 5'd0);
        send_request(52'h1_2345_6789_ABCD, 2'd0, 48'd10);
        send_request(52'h1_2345_6789_ABCD, 2'd0, 48'd20);
        send_request(52'h1_2345_6789_ABCC, 2'd1, 48'd30);
        drain();
        // level count zero and above the maximum
        write_reg(REG_LEVEL_COUNT, 3'd0);
        write_reg(REG_OFFSET_BITS, 5'd12);
        send_request(52'h0_0000_0000_0001, 2'd2, 48'd40);
        drain();
        write_reg(REG_LEVEL_COUNT, 3'd7);
        send_request(52'h0_0000_0000_0001, 2'd2, 48'd50);
        send_request(52'h8_0000_0000_0001, 2'd3, 48'd60);
        drain();
        // partitioning with too many shares and no eligible walker
        write_reg(REG_PARTITION, 1);
        write_reg(REG_BOUNDS, 64'h0000_0000_0000_1000);
        write_reg(REG_INIT_SHARES, 32'h0000_00FF);
        send_request(52'd7, 2'd1, 48'd70);
        send_request(52'd7, 2'd0, 48'd80);
        drain();
        // return mode: uniform history, then mixed
        write_reg(REG_RETURN_MODE, 1);
        send_request(52'd9, 2'd2, 48'd90);
        send_request(52'd9, 2'd2, 48'd95);
        send_request(52'd9, 2'd1, 48'd99);
        send_request(52'd9, 2'd3, 48'd120);
        drain();
        // return mode without partitioning
        write_reg(REG_PARTITION, 0);
        send_request(52'd11, 2'd0, 48'd130);
        send_request(52'd12, 2'd3, 48'd140);
        drain();

        // random phases under three idling patterns
        for (int p = 0; p < 14; p++)
        begin
            if (p == 5)
            begin
                send_idle = 70;
                recv_idle = 14;
            end
            else if (p == 10)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            setup_phase(p);
            for (int i = 0; i < 100; i++)
            begin
                send_random(p[0]);
                if (i == 50 && p % 3 == 0)
                    drain();
            end
            drain();
        end

        repeat (100) @(posedge clk);
        $display("checked %0d walk results, %0d of them granted", sb.results_seen,
                 sb.grants_seen);
        $display("covered greedy, partitioned and return modes over 14 register settings");
        if (sb.errors == 0 && sb.grants_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/spwa_pkg.sv
rtl/spwa_lat_div.sv
rtl/shared_page_walker_allocator.sv
tb/testbench.sv
